// File: rtl/slip_packet_decoder_checker_macros.svh
// Assertion macros shared by the SLIP decoder and checker RTL.
`ifndef SLIP_PACKET_DECODER_CHECKER_MACROS_SVH
`define SLIP_PACKET_DECODER_CHECKER_MACROS_SVH

`ifndef SYNTHESIS

// Property checked at every rising clock edge, disabled while reset is low.
`define SPDC_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("SLIP decoder assertion failed");

// Property checked at every rising clock edge, reset included.
`define SPDC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("SLIP decoder assertion failed");

`else

`define SPDC_ASSERT_RST(lbl, clk, rst_n, prop)
`define SPDC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// File: rtl/spdc_pkg.sv
// Types and constants of the SLIP packet decoder and checker.
package spdc_pkg;

    localparam int unsigned MAX_PACKET_BYTES_DEF = 512;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CNT_W   = 10;
    localparam int unsigned IDX_W   = 9;
    localparam int unsigned CORE_W  = 4;
    localparam int unsigned LIMIT_W = 5;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;

    localparam logic [BYTE_W-1:0] SL_END  = 8'hC0;
    localparam logic [BYTE_W-1:0] SL_ESC  = 8'hDB;
    localparam logic [BYTE_W-1:0] SL_XEND = 8'hDC;
    localparam logic [BYTE_W-1:0] SL_XESC = 8'hDD;

    localparam logic [CNT_W-1:0] MIN_PACKET = 10'd5;

    localparam logic [LIMIT_W-1:0] CORE_LIMIT_RST = 5'd16;
    localparam logic [BYTE_W-1:0]  OP_MASK_RST    = 8'd12;
    localparam logic [BYTE_W-1:0]  READ_BITS_RST  = 8'd4;

    typedef enum logic [1:0] {
        REG_CORE_LIMIT = 2'd0,
        REG_OP_MASK    = 2'd1,
        REG_READ_BITS  = 2'd2,
        REG_NONE       = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_DATA = 2'd1,
        PH_ESC  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ABORT = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_NOT_RESP = 3'd2,
        ST_BAD_CORE = 3'd3,
        ST_COUNT    = 3'd4,
        ST_OVERFLOW = 3'd5
    } t_status;

endpackage

// File: rtl/slip_packet_decoder_checker.sv
// SLIP receive decoder with response-packet checking.
//
// Input channel: i_in_valid / o_in_stall carry one raw serial byte (i_rx_byte)
// per transaction. Output channel: o_out_valid / i_out_stall carry one result
// per transaction: a decoded data byte with its index, a packet end with
// length, status, core number and read flag, or an escape abort.
// Bytes that produce no result (leading END bytes, ESC, dropped overflow
// bytes) are consumed without an output transaction.
// A byte is captured in the input register when it is accepted and passes
// through the decode logic into the result register once that register is
// empty or its transaction is taken; a receiver stall holds it back.
// Throughput is one byte per cycle while the receiver does not stall, set
// by the single decode stage that updates the packet state per byte taken.
// When the receiver stalls, the result register holds its transaction and
// the input register still fills; o_in_stall rises only when both are full.
// Reset is synchronous and active low: it empties both registers, returns
// the decoder to awaiting a packet, clears the packet state and loads the
// register defaults (core_limit 16, op_mask 12, read_bits 4).
// Registers sit on an APB-style port at byte addresses 0, 4 and 8.
`include "slip_packet_decoder_checker_macros.svh"

module slip_packet_decoder_checker #(
    parameter int unsigned MAX_PACKET_BYTES = spdc_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [spdc_pkg::BYTE_W-1:0]   i_rx_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_kind,
    output logic [spdc_pkg::BYTE_W-1:0]   o_data_byte,
    output logic [spdc_pkg::IDX_W-1:0]    o_byte_index,
    output logic [spdc_pkg::CNT_W-1:0]    o_packet_length,
    output logic [2:0]                    o_status,
    output logic [spdc_pkg::CORE_W-1:0]   o_core_number,
    output logic                          o_is_read,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [spdc_pkg::ADDR_W-1:0]   paddr,
    input  logic [spdc_pkg::DATA_W-1:0]   pwdata,
    output logic [spdc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import spdc_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PACKET_BYTES);

    // Configuration registers.
    logic [LIMIT_W-1:0] r_core_limit;
    logic [BYTE_W-1:0]  r_op_mask;
    logic [BYTE_W-1:0]  r_read_bits;
    t_reg_idx           w_reg_idx;
    logic               w_cfg_wr;

    // Input register.
    logic               r_in_valid, n_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;
    logic               w_in_acc;
    logic               w_proc;

    // Packet state.
    t_phase             r_phase, n_phase;
    logic [CNT_W-1:0]   r_byte_count, n_byte_count;
    logic [BYTE_W-1:0]  r_cmd_byte, n_cmd_byte;
    logic [BYTE_W-1:0]  r_core_byte, n_core_byte;
    logic [BYTE_W-1:0]  r_count_byte, n_count_byte;
    logic [BYTE_W-1:0]  r_last_byte, n_last_byte;
    logic               r_ovf, n_ovf;

    // Result register.
    logic               r_out_valid, n_out_valid;
    t_kind              r_kind, n_kind;
    logic [BYTE_W-1:0]  r_data_byte, n_data_byte;
    logic [IDX_W-1:0]   r_byte_index, n_byte_index;
    logic [CNT_W-1:0]   r_pkt_len, n_pkt_len;
    t_status            r_status, n_status;
    logic [CORE_W-1:0]  r_core_num, n_core_num;
    logic               r_is_read, n_is_read;
    logic               w_emit;

    // Decode helpers.
    logic               w_store;
    logic [BYTE_W-1:0]  w_store_byte;
    logic               w_finish;
    logic [CORE_W-1:0]  w_core;
    logic               w_rd;
    logic [CNT_W-1:0]   w_returned;
    logic               w_mismatch;
    t_status            w_status;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign w_reg_idx = t_reg_idx'(paddr[3:2]);
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core_limit <= CORE_LIMIT_RST;
            r_op_mask    <= OP_MASK_RST;
            r_read_bits  <= READ_BITS_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_CORE_LIMIT: r_core_limit <= pwdata[LIMIT_W-1:0];
                REG_OP_MASK:    r_op_mask    <= pwdata[BYTE_W-1:0];
                REG_READ_BITS:  r_read_bits  <= pwdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_CORE_LIMIT: prdata = DATA_W'(r_core_limit);
            REG_OP_MASK:    prdata = DATA_W'(r_op_mask);
            REG_READ_BITS:  prdata = DATA_W'(r_read_bits);
            default:        prdata = '0;
        endcase
    end

    // ---------------- handshakes ----------------
    assign w_proc     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_proc;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_acc) begin
            n_in_valid = 1'b1;
        end else if (w_proc) begin
            n_in_valid = 1'b0;
        end
    end

    // ---------------- packet-end checks ----------------
    assign w_core     = r_core_byte[CORE_W-1:0];
    assign w_rd       = |(r_cmd_byte & r_read_bits);
    assign w_returned = r_byte_count - MIN_PACKET;
    // The count byte minus the payload length must equal the last byte,
    // and a negative difference is a mismatch.
    assign w_mismatch = (w_returned > CNT_W'(r_count_byte)) ||
                        ((r_count_byte - w_returned[BYTE_W-1:0]) != r_last_byte);

    always_comb begin
        priority if (r_ovf) begin
            w_status = ST_OVERFLOW;
        end else if (r_byte_count < MIN_PACKET) begin
            w_status = ST_SHORT;
        end else if ((r_cmd_byte & r_op_mask) == '0) begin
            w_status = ST_NOT_RESP;
        end else if (LIMIT_W'(w_core) >= r_core_limit) begin
            w_status = ST_BAD_CORE;
        end else if (w_rd && w_mismatch) begin
            w_status = ST_COUNT;
        end else begin
            w_status = ST_OK;
        end
    end

    // ---------------- decode: next state and result ----------------
    always_comb begin
        n_phase      = r_phase;
        n_byte_count = r_byte_count;
        n_cmd_byte   = r_cmd_byte;
        n_core_byte  = r_core_byte;
        n_count_byte = r_count_byte;
        n_last_byte  = r_last_byte;
        n_ovf        = r_ovf;
        w_store      = 1'b0;
        w_store_byte = r_in_byte;
        w_finish     = 1'b0;
        w_emit       = 1'b0;
        n_kind       = KIND_DATA;
        n_data_byte  = '0;
        n_byte_index = '0;
        n_pkt_len    = '0;
        n_status     = ST_OK;
        n_core_num   = '0;
        n_is_read    = 1'b0;

        if (w_proc) begin
            unique case (r_phase)
                PH_ESC: begin
                    if (r_in_byte == SL_XEND) begin
                        w_store      = 1'b1;
                        w_store_byte = SL_END;
                    end else if (r_in_byte == SL_XESC) begin
                        w_store      = 1'b1;
                        w_store_byte = SL_ESC;
                    end else begin
                        // Bad escape: drop the packet and report it.
                        w_emit       = 1'b1;
                        n_kind       = KIND_ABORT;
                        n_phase      = PH_WAIT;
                        n_byte_count = '0;
                        n_cmd_byte   = '0;
                        n_core_byte  = '0;
                        n_count_byte = '0;
                        n_last_byte  = '0;
                        n_ovf        = 1'b0;
                    end
                end
                PH_WAIT, PH_DATA: begin
                    if (r_in_byte == SL_END) begin
                        w_finish = (r_phase == PH_DATA);
                    end else if (r_in_byte == SL_ESC) begin
                        n_phase = PH_ESC;
                    end else begin
                        w_store = 1'b1;
                    end
                end
                default: ;
            endcase

            if (w_store) begin
                n_phase = PH_DATA;
                if (r_byte_count >= MAX_CNT) begin
                    n_ovf = 1'b1;
                end else begin
                    w_emit       = 1'b1;
                    n_kind       = KIND_DATA;
                    n_data_byte  = w_store_byte;
                    n_byte_index = r_byte_count[IDX_W-1:0];
                    n_byte_count = r_byte_count + 1'b1;
                    n_last_byte  = w_store_byte;
                    if (r_byte_count == 10'd0) begin
                        n_cmd_byte = w_store_byte;
                    end
                    if (r_byte_count == 10'd1) begin
                        n_core_byte = w_store_byte;
                    end
                    if (r_byte_count == 10'd3) begin
                        n_count_byte = w_store_byte;
                    end
                end
            end

            if (w_finish) begin
                w_emit       = 1'b1;
                n_kind       = KIND_END;
                n_pkt_len    = r_byte_count;
                n_status     = w_status;
                n_core_num   = w_core;
                n_is_read    = w_rd;
                n_phase      = PH_WAIT;
                n_byte_count = '0;
                n_cmd_byte   = '0;
                n_core_byte  = '0;
                n_count_byte = '0;
                n_last_byte  = '0;
                n_ovf        = 1'b0;
            end
        end

        n_out_valid = r_out_valid && i_out_stall;
        if (w_proc) begin
            n_out_valid = w_emit;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_phase      <= PH_WAIT;
            r_byte_count <= '0;
            r_cmd_byte   <= '0;
            r_core_byte  <= '0;
            r_count_byte <= '0;
            r_last_byte  <= '0;
            r_ovf        <= 1'b0;
        end else begin
            r_in_valid   <= n_in_valid;
            r_out_valid  <= n_out_valid;
            r_phase      <= n_phase;
            r_byte_count <= n_byte_count;
            r_cmd_byte   <= n_cmd_byte;
            r_core_byte  <= n_core_byte;
            r_count_byte <= n_count_byte;
            r_last_byte  <= n_last_byte;
            r_ovf        <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_byte <= i_rx_byte;
        end
        if (w_proc && w_emit) begin
            r_kind       <= n_kind;
            r_data_byte  <= n_data_byte;
            r_byte_index <= n_byte_index;
            r_pkt_len    <= n_pkt_len;
            r_status     <= n_status;
            r_core_num   <= n_core_num;
            r_is_read    <= n_is_read;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_kind;
    assign o_data_byte     = r_data_byte;
    assign o_byte_index    = r_byte_index;
    assign o_packet_length = r_pkt_len;
    assign o_status        = r_status;
    assign o_core_number   = r_core_num;
    assign o_is_read       = r_is_read;

    // ---------------- assertions ----------------
    `SPDC_ASSERT_RST(a_count_bound, i_clk, i_rst_n, r_byte_count <= MAX_CNT)
    `SPDC_ASSERT_RST(a_ovf_full, i_clk, i_rst_n, r_ovf |-> (r_byte_count == MAX_CNT))
    `SPDC_ASSERT_RST(a_wait_clean, i_clk, i_rst_n, (r_phase == PH_WAIT) |-> ((r_byte_count == '0) && !r_ovf))
    `SPDC_ASSERT_RST(a_data_counts, i_clk, i_rst_n, (w_proc && w_emit && (n_kind == KIND_DATA)) |=> (r_byte_count == $past(r_byte_count) + 1'b1))

endmodule

// File: verif/slip_stream_checker.sv
// Checker that predicts every SLIP decoder result and compares it with the block.
`timescale 1ns / 100ps

module slip_stream_checker
    import spdc_pkg::*;
#(
    parameter int unsigned MAX_BYTES = MAX_PACKET_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [BYTE_W-1:0]  i_rx_byte,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [1:0]         i_kind,
    input  logic [BYTE_W-1:0]  i_data_byte,
    input  logic [IDX_W-1:0]   i_byte_index,
    input  logic [CNT_W-1:0]   i_packet_length,
    input  logic [2:0]         i_status,
    input  logic [CORE_W-1:0]  i_core_number,
    input  logic               i_is_read,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    input  logic               pready,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_result_count,
    output int                 o_end_count
);

    typedef struct packed {
        t_kind               kind;
        logic [BYTE_W-1:0]   data;
        logic [IDX_W-1:0]    byte_pos;
        logic [CNT_W-1:0]    pkt_length;
        t_status             status;
        logic [CORE_W-1:0]   core;
        logic                is_read;
    } t_decode_result;

    t_decode_result expected_results[$];

    // Register copies, updated from the writes seen on the APB port.
    logic [LIMIT_W-1:0] core_limit;
    logic [BYTE_W-1:0]  op_mask;
    logic [BYTE_W-1:0]  read_bits;

    // Packet state of the decoder.
    t_phase             rx_phase;
    logic [CNT_W-1:0]   pkt_len;
    logic [BYTE_W-1:0]  pkt_command;
    logic [BYTE_W-1:0]  pkt_core;
    logic [BYTE_W-1:0]  pkt_count;
    logic [BYTE_W-1:0]  pkt_last;
    logic               pkt_overflow;

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        if (o_fail_count <= 30) begin
            $display("MISMATCH at result %0d (t=%0t): %s", o_result_count, $time, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    function automatic void clear_packet_state();
        pkt_len      = '0;
        pkt_command  = '0;
        pkt_core     = '0;
        pkt_count    = '0;
        pkt_last     = '0;
        pkt_overflow = 1'b0;
    endfunction

    // A byte that finds the buffer full is dropped and only marks the packet.
    function automatic bit store_decoded(input logic [BYTE_W-1:0] b,
                                         output t_decode_result res);
        res = '0;
        if (pkt_len >= MAX_BYTES) begin
            pkt_overflow = 1'b1;
            return 1'b0;
        end
        case (pkt_len)
            10'd0: pkt_command = b;
            10'd1: pkt_core = b;
            10'd3: pkt_count = b;
            default: ;
        endcase
        pkt_last     = b;
        res.kind     = KIND_DATA;
        res.data     = b;
        res.byte_pos = pkt_len[IDX_W-1:0];
        pkt_len      = pkt_len + 1'b1;
        return 1'b1;
    endfunction

    function automatic bit decode_rx_byte(input logic [BYTE_W-1:0] rx,
                                          output t_decode_result res);
        logic [CORE_W-1:0] core;
        logic              rd;
        int unsigned       returned;
        res = '0;
        if (rx_phase == PH_ESC) begin
            if (rx == SL_XEND) begin
                rx_phase = PH_DATA;
                return store_decoded(SL_END, res);
            end
            if (rx == SL_XESC) begin
                rx_phase = PH_DATA;
                return store_decoded(SL_ESC, res);
            end
            res.kind = KIND_ABORT;
            clear_packet_state();
            rx_phase = PH_WAIT;
            return 1'b1;
        end
        if (rx_phase == PH_WAIT) begin
            if (rx == SL_END) begin
                return 1'b0;
            end
            rx_phase = PH_DATA;
        end
        if (rx == SL_END) begin
            core = pkt_core[CORE_W-1:0];
            rd   = (pkt_command & read_bits) != '0;
            res.kind       = KIND_END;
            res.pkt_length = pkt_len;
            res.core       = core;
            res.is_read    = rd;
            res.status     = ST_OK;
            if (pkt_overflow) begin
                res.status = ST_OVERFLOW;
            end else if (pkt_len < MIN_PACKET) begin
                res.status = ST_SHORT;
            end else if ((pkt_command & op_mask) == '0) begin
                res.status = ST_NOT_RESP;
            end else if (core >= core_limit) begin
                res.status = ST_BAD_CORE;
            end else if (rd) begin
                // The trailing byte carries the count left after the payload.
                returned = pkt_len - MIN_PACKET;
                if (returned > pkt_count || pkt_count - returned != pkt_last) begin
                    res.status = ST_COUNT;
                end
            end
            clear_packet_state();
            rx_phase = PH_WAIT;
            return 1'b1;
        end
        if (rx == SL_ESC) begin
            rx_phase = PH_ESC;
            return 1'b0;
        end
        return store_decoded(rx, res);
    endfunction

    always @(posedge i_clk) begin : watch
        t_decode_result want;
        if (!i_rst_n) begin
            core_limit = CORE_LIMIT_RST;
            op_mask    = OP_MASK_RST;
            read_bits  = READ_BITS_RST;
            rx_phase   = PH_WAIT;
            clear_packet_state();
            expected_results.delete();
            o_fail_count   = 0;
            o_result_count = 0;
            o_end_count    = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_result_count++;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("kind %0d arrived with nothing expected", i_kind));
                end else begin
                    want = expected_results.pop_front();
                    if (want.kind == KIND_END) begin
                        o_end_count++;
                    end
                    check_field("kind", i_kind, want.kind);
                    check_field("data_byte", i_data_byte, want.data);
                    check_field("byte_index", i_byte_index, want.byte_pos);
                    check_field("packet_length", i_packet_length, want.pkt_length);
                    check_field("status", i_status, want.status);
                    check_field("core_number", i_core_number, want.core);
                    check_field("is_read", i_is_read, want.is_read);
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[3:2]))
                    REG_CORE_LIMIT: core_limit = pwdata[LIMIT_W-1:0];
                    REG_OP_MASK:    op_mask = pwdata[BYTE_W-1:0];
                    REG_READ_BITS:  read_bits = pwdata[BYTE_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (decode_rx_byte(i_rx_byte, want)) begin
                    expected_results.push_back(want);
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// File: verif/tb_slip_packet_decoder_checker.sv
// Testbench top: stimulus, flow control and verdict for the SLIP decoder.
`timescale 1ns / 100ps

module tb_slip_packet_decoder_checker;
    import spdc_pkg::*;

    localparam int unsigned PHASE_ITEMS  = 60;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    logic                 clk;
    logic                 rst_n    = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [BYTE_W-1:0]    rx_byte  = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           kind;
    logic [BYTE_W-1:0]    data_byte;
    logic [IDX_W-1:0]     byte_index;
    logic [CNT_W-1:0]     packet_length;
    logic [2:0]           status;
    logic [CORE_W-1:0]    core_number;
    logic                 is_read;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [ADDR_W-1:0]    paddr   = '0;
    logic [DATA_W-1:0]    pwdata  = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    int          fail_count;
    int          pending;
    int          result_count;
    int          end_count;
    int unsigned in_idle_pct   = 0;
    int unsigned out_stall_pct = 0;
    logic        hold_off      = 1'b0;
    int unsigned item_count    = 0;
    int unsigned cycle_count   = 0;
    int unsigned input_stall_cycles = 0;
    int unsigned settings_count = 1;

    // Leading ENDs, a short packet, escaped END and ESC, a good read response,
    // a bad escape, and an ESC cut off by END.
    logic [BYTE_W-1:0] directed_stream [0:20] = '{
        SL_END, SL_END,
        8'h01, SL_END,
        SL_ESC, SL_XEND, SL_ESC, SL_XESC, 8'hFF, 8'h00, SL_END,
        8'h04, 8'h03, 8'hAA, 8'h02, 8'h02, SL_END,
        SL_ESC, 8'h41,
        SL_ESC, SL_END
    };

    slip_packet_decoder_checker DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_rx_byte       (rx_byte),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_kind          (kind),
        .o_data_byte     (data_byte),
        .o_byte_index    (byte_index),
        .o_packet_length (packet_length),
        .o_status        (status),
        .o_core_number   (core_number),
        .o_is_read       (is_read),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    slip_stream_checker stream_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_rx_byte       (rx_byte),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_kind          (kind),
        .i_data_byte     (data_byte),
        .i_byte_index    (byte_index),
        .i_packet_length (packet_length),
        .i_status        (status),
        .i_core_number   (core_number),
        .i_is_read       (is_read),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_result_count  (result_count),
        .o_end_count     (end_count)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (in_valid && in_stall) begin
            input_stall_cycles++;
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
                     pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : receiver
        forever begin
            @(negedge clk);
            out_stall <= hold_off || ($urandom_range(99) < out_stall_pct);
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < in_idle_pct) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (in_stall);
        item_count++;
    endtask

    task automatic send_decoded(input logic [BYTE_W-1:0] b);
        if (b == SL_END) begin
            send_byte(SL_ESC);
            send_byte(SL_XEND);
        end else if (b == SL_ESC) begin
            send_byte(SL_ESC);
            send_byte(SL_XESC);
        end else begin
            send_byte(b);
        end
    endtask

    // Framing codes turn up often so that escapes and stray ENDs are common.
    function automatic logic [BYTE_W-1:0] pick_data_byte();
        case ($urandom_range(15))
            0: return SL_END;
            1: return SL_ESC;
            2: return SL_XEND;
            3: return SL_XESC;
            default: return BYTE_W'($urandom_range(255));
        endcase
    endfunction

    task automatic send_random_packet();
        int unsigned       shape;
        int unsigned       len;
        logic [BYTE_W-1:0] count_byte;
        logic [BYTE_W-1:0] b;
        shape = $urandom_range(99);
        if (shape < 8) begin
            // Line noise sent raw, framing codes included.
            repeat ($urandom_range(6, 1)) send_byte(pick_data_byte());
        end else if (shape < 16) begin
            // A packet broken off by an invalid escape.
            repeat ($urandom_range(4)) send_decoded(pick_data_byte());
            send_byte(SL_ESC);
            do b = BYTE_W'($urandom_range(255)); while (b == SL_XEND || b == SL_XESC);
            send_byte(b);
        end else begin
            if ($urandom_range(3) == 0) begin
                send_byte(SL_END);
            end
            len = ($urandom_range(3) == 0) ? $urandom_range(12, 1) : $urandom_range(9, 5);
            count_byte = ($urandom_range(1) == 0) ? BYTE_W'($urandom_range(7))
                                                  : BYTE_W'($urandom_range(255));
            for (int unsigned i = 0; i < len; i++) begin
                if (len >= 5 && i == len - 1 && $urandom_range(3) != 0) begin
                    b = count_byte - BYTE_W'(len - 5);
                end else if (i == 0) begin
                    case ($urandom_range(3))
                        0: b = 8'h04;
                        1: b = 8'h08;
                        2: b = 8'h0C | BYTE_W'($urandom_range(255));
                        default: b = BYTE_W'($urandom_range(255));
                    endcase
                end else if (i == 3) begin
                    b = count_byte;
                end else begin
                    b = pick_data_byte();
                end
                send_decoded(b);
            end
            send_byte(SL_END);
        end
    endtask

    task automatic run_random_phase();
        int unsigned phase_start;
        phase_start = item_count;
        while (item_count - phase_start < PHASE_ITEMS) begin
            send_random_packet();
        end
    endtask

    // Bytes that give no result may still be in flight once the last expected
    // result is in, so the task idles the input for a drain period before returning.
    task automatic drain_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_settings(input logic [DATA_W-1:0] limit,
                                  input logic [DATA_W-1:0] mask,
                                  input logic [DATA_W-1:0] rbits);
        drain_block();
        write_register(REG_CORE_LIMIT, limit);
        write_register(REG_OP_MASK, mask);
        write_register(REG_READ_BITS, rbits);
        settings_count++;
    endtask

    initial begin : stimulus
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_stream[i]) begin
            send_byte(directed_stream[i]);
        end

        // Long receiver hold-off while the sender keeps offering bytes.
        fork
            begin
                @(posedge clk);
                hold_off = 1'b1;
                repeat (60) @(posedge clk);
                hold_off = 1'b0;
            end
        join_none
        run_random_phase();

        apply_settings(32'd1, 32'hFF, 32'hFF);
        in_idle_pct = 51;
        // One packet past capacity: the tail is dropped and flagged.
        repeat (515) send_decoded(pick_data_byte());
        send_byte(SL_END);
        run_random_phase();

        apply_settings(32'd0, 32'h01, 32'h80);
        in_idle_pct   = 0;
        out_stall_pct = 51;
        run_random_phase();

        apply_settings(32'd31, 32'h00, 32'h00);
        in_idle_pct   = 23;
        out_stall_pct = 23;
        run_random_phase();

        apply_settings(($urandom() & ~32'h1F) | $urandom_range(16, 1), $urandom(), $urandom());
        in_idle_pct   = 0;
        out_stall_pct = 0;
        run_random_phase();

        drain_block();
        $display("Sent %0d serial bytes; checked %0d results, %0d of them packet ends.",
                 item_count, result_count, end_count);
        $display("Used %0d register settings; input held off for %0d cycles; %0d mismatches.",
                 settings_count, input_stall_cycles, fail_count);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/spdc_pkg.sv
rtl/slip_packet_decoder_checker.sv
verif/slip_stream_checker.sv
verif/tb_slip_packet_decoder_checker.sv
